FILE: rtl/core/clp_pkg.sv
// Package for the calibrated line position block: widths, constants and shared types.
`timescale 1ns / 1ps
`default_nettype none
package clp_pkg;
	localparam int SENSORS = 5;
	localparam int RAW_W = 10;
	localparam int NORM_W = 9;
	localparam int POS_W = 11;
	localparam logic [NORM_W-1:0] NORM_MAX = 9'd500;
	localparam logic [NORM_W-1:0] LINE_THR_RESET = 9'd100;
	localparam logic [NORM_W-1:0] NOISE_THR_RESET = 9'd50;
	localparam logic OP_CAL = 1'b0;
	localparam logic OP_READ = 1'b1;
	localparam logic CFG_LINE_THR = 1'b0;
	localparam logic CFG_NOISE_THR = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCALE,
		ST_MERGE,
		ST_DIV
	} state_t;

	// Control from the sequencer to the lanes.
	typedef struct packed {
		logic start;
		logic cal;
		logic calibrated;
	} lane_ctrl_t;
endpackage
`default_nettype wire

FILE: rtl/core/clp_lane.sv
// One sensor lane: stored range, calibration update and serial scaling to 0..500.
`timescale 1ns / 1ps
`default_nettype none
module clp_lane #(
	parameter int TIMEOUT = 1000
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire clp_pkg::lane_ctrl_t        ctrl,
	input  wire logic [clp_pkg::RAW_W-1:0]  raw,
	output logic [clp_pkg::NORM_W-1:0]      norm,
	output logic                            done
);
	// A timeout beyond the raw field's reach never clips, which is the same as clipping at
	// the largest raw value.
	localparam int TMO_I = (TIMEOUT > (2 ** clp_pkg::RAW_W) - 1) ?
		(2 ** clp_pkg::RAW_W) - 1 : TIMEOUT;
	localparam logic [clp_pkg::RAW_W-1:0] TMO = clp_pkg::RAW_W'(TMO_I);
	localparam int NUM_W = 19;
	localparam int QB = 9;

	logic [clp_pkg::RAW_W-1:0] min_q, max_q, clip;
	logic [NUM_W-1:0] rem_q;
	logic [clp_pkg::RAW_W-1:0] den_q;
	logic [clp_pkg::NORM_W-1:0] quo_q;
	logic [3:0] cnt_q;
	logic busy_q;
	logic [NUM_W:0] trial;

	assign clip = (raw > TMO) ? TMO : raw;
	assign trial = {1'b0, rem_q} - ({10'd0, den_q} << cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= TMO;
			max_q <= '0;
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (ctrl.start && ctrl.cal) begin
				if (clip < min_q) min_q <= clip;
				if (clip > max_q) max_q <= clip;
			end else if (ctrl.start) begin
				if (!ctrl.calibrated || max_q <= min_q || clip <= min_q) begin
					quo_q <= '0;
					done <= 1'b1;
				end else if ((clip - min_q) >= (max_q - min_q)) begin
					quo_q <= clp_pkg::NORM_MAX;
					done <= 1'b1;
				end else begin
					rem_q <= NUM_W'(clip - min_q) * NUM_W'(clp_pkg::NORM_MAX);
					den_q <= max_q - min_q;
					quo_q <= '0;
					cnt_q <= 4'(QB - 1);
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				// Restoring division, one quotient bit a cycle.
				if (!trial[NUM_W]) begin
					rem_q <= trial[NUM_W-1:0];
					quo_q[cnt_q] <= 1'b1;
				end
				if (cnt_q == 4'd0) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 4'd1;
				end
			end
		end
	end
	assign norm = quo_q;
endmodule
`default_nettype wire

FILE: rtl/core/clp_merge.sv
// Merging stage: serial weighted sum over middle lanes and serial centroid division.
`timescale 1ns / 1ps
`default_nettype none
module clp_merge (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [clp_pkg::NORM_W-1:0]   norm [clp_pkg::SENSORS],
	input  wire logic [clp_pkg::NORM_W-1:0]   line_thr,
	input  wire logic [clp_pkg::NORM_W-1:0]   noise_thr,
	output logic [clp_pkg::POS_W-1:0]         position,
	output logic                              on_line,
	output logic                              done
);
	localparam int POS_W = clp_pkg::POS_W;
	localparam int MID = clp_pkg::SENSORS - 2;
	localparam int IW = $clog2(MID + 1);
	localparam int NW = $clog2(clp_pkg::SENSORS);
	localparam int SPAN = (clp_pkg::SENSORS - 3) * 1000;
	localparam int SUM_W = 13;
	localparam int AVG_W = 28;

	logic [IW-1:0] idx_q;
	logic [SUM_W-1:0] sum_q;
	logic [AVG_W-1:0] avg_q;
	logic [clp_pkg::POS_W-1:0] last_q, quo_q;
	logic [4:0] bit_q;
	logic seen_q, acc_q, div_q;
	logic [clp_pkg::NORM_W-1:0] v;
	logic [AVG_W+SUM_W:0] trial;

	assign v = norm[NW'(idx_q) + NW'(1)];
	assign trial = {{(SUM_W+1){1'b0}}, avg_q} - ({{(AVG_W+1){1'b0}}, sum_q} << bit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			acc_q <= 1'b0;
			div_q <= 1'b0;
			done <= 1'b0;
			idx_q <= '0;
			bit_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				idx_q <= '0;
				sum_q <= '0;
				avg_q <= '0;
				seen_q <= 1'b0;
				acc_q <= 1'b1;
			end else if (acc_q) begin
				if (v > line_thr) seen_q <= 1'b1;
				if (v > noise_thr) begin
					sum_q <= sum_q + SUM_W'(v);
					avg_q <= avg_q + AVG_W'(v) * AVG_W'(idx_q) * AVG_W'(1000);
				end
				if (idx_q == IW'(MID - 1)) begin
					acc_q <= 1'b0;
					div_q <= 1'b1;
					bit_q <= 5'(clp_pkg::POS_W - 1);
					quo_q <= '0;
				end else begin
					idx_q <= idx_q + IW'(1);
				end
			end else if (div_q) begin
				if (!trial[AVG_W+SUM_W] && sum_q != '0) begin
					avg_q <= trial[AVG_W-1:0];
					quo_q[bit_q[3:0]] <= 1'b1;
				end
				if (bit_q == 5'd0) begin
					div_q <= 1'b0;
					done <= 1'b1;
					on_line <= seen_q;
					if (!seen_q) begin
						position <= (last_q < POS_W'(SPAN / 2)) ? '0 : POS_W'(SPAN);
					end else if (sum_q != '0) begin
						position <= quo_q | POS_W'(!trial[AVG_W+SUM_W]);
						last_q <= quo_q | POS_W'(!trial[AVG_W+SUM_W]);
					end else begin
						position <= last_q;
					end
				end else begin
					bit_q <= bit_q - 5'd1;
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/calibrated_line_position.sv
// Top level of the calibrated line position block.
`timescale 1ns / 1ps
`default_nettype none
// A calibrate word (op 0) widens every sensor's stored minimum and maximum at the edge that
// accepts it and gives no result, so the next word can be accepted in the following cycle.
// A read word (op 1) scales all five sensors in parallel lanes. A lane whose answer is zero or
// full scale finishes without dividing; any other lane runs a restoring divider. The merging
// stage then walks the three middle sensors one per cycle and serially divides the weighted
// sum by the sum of the values above the noise threshold, and the ST_DIV state moves the
// result into the output register. A read holds the input stalled through the lane and
// centroid dividers and the ST_DIV state, also while the previous result still waits in the
// output register. Only one word is processed at a time; a finished result sits in the
// output register while the next word is already accepted.
module calibrated_line_position #(
	parameter int TIMEOUT = 1000
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        op,
	input  wire logic [9:0]  raw_0,
	input  wire logic [9:0]  raw_1,
	input  wire logic [9:0]  raw_2,
	input  wire logic [9:0]  raw_3,
	input  wire logic [9:0]  raw_4,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [10:0]      position,
	output logic             on_line,
	output logic             is_calibrated,
	output logic [8:0]       norm_0,
	output logic [8:0]       norm_1,
	output logic [8:0]       norm_2,
	output logic [8:0]       norm_3,
	output logic [8:0]       norm_4,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [8:0]  cfg_data
);
	clp_pkg::state_t state_q, state_d;
	logic [8:0] line_thr_q, noise_thr_q;
	logic cal_flag_q, cal_snap_q;
	logic [9:0] raw_w [clp_pkg::SENSORS];
	logic [8:0] norm_w [clp_pkg::SENSORS];
	logic [clp_pkg::SENSORS-1:0] ldone;
	logic ldone_all;
	logic [clp_pkg::SENSORS-1:0] ldone_seen_q;
	logic accept, mstart, mdone;
	logic [10:0] mpos;
	logic mline;
	clp_pkg::lane_ctrl_t lctrl;

	assign raw_w[0] = raw_0;
	assign raw_w[1] = raw_1;
	assign raw_w[2] = raw_2;
	assign raw_w[3] = raw_3;
	assign raw_w[4] = raw_4;

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != clp_pkg::ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign lctrl.start = accept;
	assign lctrl.cal = (op == clp_pkg::OP_CAL);
	assign lctrl.calibrated = cal_flag_q;

	for (genvar g = 0; g < clp_pkg::SENSORS; g++) begin : g_lane
		clp_lane #(.TIMEOUT(TIMEOUT)) u_lane (
			.clk(clk), .arst_n(arst_n), .ctrl(lctrl), .raw(raw_w[g]),
			.norm(norm_w[g]), .done(ldone[g]));
	end

	clp_merge u_merge (
		.clk(clk), .arst_n(arst_n), .start(mstart), .norm(norm_w),
		.line_thr(line_thr_q), .noise_thr(noise_thr_q),
		.position(mpos), .on_line(mline), .done(mdone));

	assign ldone_all = &(ldone_seen_q | ldone);
	assign mstart = (state_q == clp_pkg::ST_SCALE) && ldone_all;

	always_comb begin
		state_d = state_q;
		case (state_q)
			clp_pkg::ST_IDLE: begin
				if (accept) state_d = (op == clp_pkg::OP_READ) ? clp_pkg::ST_SCALE
					: clp_pkg::ST_IDLE;
			end
			clp_pkg::ST_SCALE: if (ldone_all) state_d = clp_pkg::ST_MERGE;
			clp_pkg::ST_MERGE: if (mdone) state_d = clp_pkg::ST_DIV;
			// Wait until the previous result has left the output register.
			clp_pkg::ST_DIV: if (!out_valid || !out_stall) state_d = clp_pkg::ST_IDLE;
			default: state_d = clp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clp_pkg::ST_IDLE;
			line_thr_q <= clp_pkg::LINE_THR_RESET;
			noise_thr_q <= clp_pkg::NOISE_THR_RESET;
			cal_flag_q <= 1'b0;
			out_valid <= 1'b0;
			ldone_seen_q <= '0;
			cal_snap_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == clp_pkg::CFG_LINE_THR) line_thr_q <= cfg_data;
				else noise_thr_q <= cfg_data;
			end
			if (accept) begin
				cal_snap_q <= cal_flag_q;
				ldone_seen_q <= '0;
				if (op == clp_pkg::OP_CAL) cal_flag_q <= 1'b1;
			end else begin
				ldone_seen_q <= ldone_seen_q | ldone;
			end
			if (state_q == clp_pkg::ST_DIV && (!out_valid || !out_stall)) begin
				out_valid <= 1'b1;
				position <= mpos;
				on_line <= mline;
				is_calibrated <= cal_snap_q;
				norm_0 <= norm_w[0]; norm_1 <= norm_w[1]; norm_2 <= norm_w[2];
				norm_3 <= norm_w[3]; norm_4 <= norm_w[4];
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == clp_pkg::ST_SCALE) |-> in_stall) else $error("accept during scaling");
	a_cal_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cal_flag_q) |-> cal_flag_q) else $error("calibrated flag cleared");
	a_uncal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_calibrated) |-> (!on_line && norm_2 == '0))
		else $error("uncalibrated result not zero");
`endif
endmodule
`default_nettype wire
